/* rtl/obpa_pkg.sv */
`timescale 1ns / 1ps
package obpa_pkg;

  localparam int MAX_BINS = 64;
  localparam int IDX_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W    = $clog2(MAX_BINS + 1);

  localparam int SIZE_W   = 10;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = 10'd700;

  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;

  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'd1;

  // Search token that walks down the row of bin cells.
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] size;
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic [SIZE_W-1:0] left;
  } tok_t;

  // Room update broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] room;
  } wr_t;

endpackage

/* rtl/online_bin_packing_allocator.sv */
`timescale 1ns / 1ps
// Online bin packing allocator. Each place word carries an item size and returns the
// bin that took it (next fit, first fit or best fit, chosen by fit_mode; mode three
// acts as best fit); a clear word closes all bins. Each bin's remaining room sits in
// its own cell of a row of MAX_BINS cells, and a search token steps one cell per
// clock through every cell before a place word's result is formed; clear words and
// oversized items skip the search. One word is in work at a time, and the next is
// taken while an earlier result still waits on the output. Write configuration
// only while no word is in work.
module online_bin_packing_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // item_size[9:0], zero pad
  input  logic [0:0]                     in_tuser,   // action[0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // bin_index[5:0], opened_new[6],
                                                     // status[8:7], zero pad
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [obpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [obpa_pkg::SIZE_W-1:0]    cfg_data
);

  obpa_pkg::tok_t tok_chain [0:obpa_pkg::MAX_BINS];
  obpa_pkg::wr_t  wr;

  obpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tok_launch (tok_chain[0]),
    .tok_ret    (tok_chain[obpa_pkg::MAX_BINS]),
    .wr         (wr)
  );

  for (genvar i = 0; i < obpa_pkg::MAX_BINS; i++) begin : g_cell
    obpa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (obpa_pkg::IDX_W'(i)),
      .tok_in   (tok_chain[i]),
      .tok_out  (tok_chain[i+1]),
      .wr       (wr)
    );
  end

endmodule

/* rtl/obpa_cell.sv */
`timescale 1ns / 1ps
module obpa_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [obpa_pkg::IDX_W-1:0] cell_idx,
  input  obpa_pkg::tok_t             tok_in,
  output obpa_pkg::tok_t             tok_out,
  input  obpa_pkg::wr_t              wr
);

  logic [obpa_pkg::SIZE_W-1:0] room_r;
  obpa_pkg::tok_t              tok_r;
  obpa_pkg::tok_t              tok_nxt;

  logic [obpa_pkg::CNT_W-1:0]  idx_ext;
  logic                        is_open;
  logic                        is_last;
  logic                        fit;
  logic [obpa_pkg::SIZE_W-1:0] left;
  logic                        take;

  assign idx_ext = obpa_pkg::CNT_W'(cell_idx);
  assign is_open = idx_ext < tok_in.count;
  assign is_last = (idx_ext + obpa_pkg::CNT_W'(1)) == tok_in.count;
  assign fit     = is_open && (tok_in.size <= room_r);
  assign left    = room_r - tok_in.size;

  always_comb begin
    unique case (tok_in.mode)
      obpa_pkg::MODE_NEXT:  take = is_last && fit;
      obpa_pkg::MODE_FIRST: take = fit && !tok_in.found;
      default:              take = fit && (!tok_in.found || (left < tok_in.left));
    endcase
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.pick  = cell_idx;
      tok_nxt.left  = left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      room_r <= wr.room;
    end
  end

  assign tok_out = tok_r;

endmodule

/* rtl/obpa_ctrl.sv */
`timescale 1ns / 1ps
module obpa_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [obpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [obpa_pkg::SIZE_W-1:0]    cfg_data,
  output obpa_pkg::tok_t                 tok_launch,
  input  obpa_pkg::tok_t                 tok_ret,
  output obpa_pkg::wr_t                  wr
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [obpa_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [obpa_pkg::SIZE_W-1:0] cap_r;
  logic [obpa_pkg::MODE_W-1:0] mode_r;
  obpa_pkg::tok_t              launch_r, launch_nxt;
  obpa_pkg::wr_t               wr_r, wr_nxt;

  logic [obpa_pkg::IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic                        res_open_r, res_open_nxt;
  logic [1:0]                  res_st_r, res_st_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [5:0]                  out_idx_r;
  logic                        out_open_r;
  logic [1:0]                  out_st_r;

  logic                        in_acc;
  logic                        out_free;
  logic [obpa_pkg::SIZE_W-1:0] in_size;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_size   = in_tdata[obpa_pkg::SIZE_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    launch_nxt   = launch_r;
    launch_nxt.valid = 1'b0;
    wr_nxt       = wr_r;
    wr_nxt.en    = 1'b0;
    res_idx_nxt  = res_idx_r;
    res_open_nxt = res_open_r;
    res_st_nxt   = res_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_idx_nxt  = '0;
          res_open_nxt = 1'b0;
          if (in_tuser[0] == obpa_pkg::ACT_CLEAR) begin
            count_nxt  = '0;
            res_st_nxt = obpa_pkg::ST_OK;
            state_nxt  = S_DONE;
          end else if (in_size > cap_r) begin
            res_st_nxt = obpa_pkg::ST_OVER;
            state_nxt  = S_DONE;
          end else begin
            launch_nxt.valid = 1'b1;
            launch_nxt.size  = in_size;
            launch_nxt.mode  = mode_r;
            launch_nxt.count = count_r;
            launch_nxt.found = 1'b0;
            launch_nxt.pick  = '0;
            launch_nxt.left  = '0;
            state_nxt        = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (tok_ret.valid) begin
          state_nxt = S_DONE;
          if (tok_ret.found) begin
            wr_nxt.en    = 1'b1;
            wr_nxt.idx   = tok_ret.pick;
            wr_nxt.room  = tok_ret.left;
            res_idx_nxt  = tok_ret.pick;
            res_open_nxt = 1'b0;
            res_st_nxt   = obpa_pkg::ST_OK;
          end else if (count_r >= obpa_pkg::CNT_W'(obpa_pkg::MAX_BINS)) begin
            res_idx_nxt  = '0;
            res_open_nxt = 1'b0;
            res_st_nxt   = obpa_pkg::ST_FULL;
          end else begin
            // Open a fresh bin right after the last open one.
            wr_nxt.en    = 1'b1;
            wr_nxt.idx   = count_r[obpa_pkg::IDX_W-1:0];
            wr_nxt.room  = cap_r - tok_ret.size;
            count_nxt    = count_r + obpa_pkg::CNT_W'(1);
            res_idx_nxt  = count_r[obpa_pkg::IDX_W-1:0];
            res_open_nxt = 1'b1;
            res_st_nxt   = obpa_pkg::ST_OK;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      launch_r.valid <= 1'b0;
      wr_r.en        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      launch_r    <= launch_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_idx_r  <= res_idx_nxt;
    res_open_r <= res_open_nxt;
    res_st_r   <= res_st_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_idx_r  <= 6'(res_idx_r);
      out_open_r <= res_open_r;
      out_st_r   <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= obpa_pkg::CAPACITY_RESET;
      mode_r <= obpa_pkg::MODE_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        obpa_pkg::REG_CAPACITY: cap_r  <= cfg_data;
        obpa_pkg::REG_MODE:     mode_r <= cfg_data[obpa_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_st_r, out_open_r, out_idx_r};
  assign tok_launch = launch_r;
  assign wr         = wr_r;

endmodule

/* rtl/obpa_checker.sv */
`timescale 1ns / 1ps
module obpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:7] != 2'b11)
    else $error("undefined status code");

  a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[8:7] == obpa_pkg::ST_OK)
    else $error("new bin reported together with an error status");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[8:7] != obpa_pkg::ST_OK) |-> out_tdata[5:0] == 6'd0)
    else $error("error result carries a bin index");

endmodule

bind online_bin_packing_allocator obpa_checker u_obpa_checker (.*);

/* dv/bin_alloc_checker.sv */
`timescale 1ns / 1ps
module bin_alloc_checker
  import obpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,   // item_size[9:0], zero pad
  input  logic [0:0]           in_tuser,   // action[0]
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata,  // bin_index[5:0], opened_new[6], status[8:7], zero pad
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   checked,
  output int                   new_bins,
  output int                   over_hits,
  output int                   full_hits
);

  // Packed so that it lines up with the low nine bits of out_tdata.
  typedef struct packed {
    logic [1:0]       status;
    logic             opened_new;
    logic [IDX_W-1:0] bin_index;
  } placement_t;

  logic [SIZE_W-1:0] room_q [MAX_BINS];
  int                open_cnt;
  logic [SIZE_W-1:0] cap_q;
  logic [MODE_W-1:0] mode_q;
  placement_t        placement_q [$];
  int                fail_cnt;
  int                checked_cnt;
  int                new_cnt;
  int                over_cnt;
  int                full_cnt;

  assign errors    = fail_cnt;
  assign checked   = checked_cnt;
  assign new_bins  = new_cnt;
  assign over_hits = over_cnt;
  assign full_hits = full_cnt;

  // Works out where one item lands and updates the bin state to match.
  function automatic placement_t place_item(input logic act, input logic [SIZE_W-1:0] sz);
    placement_t        res;
    logic              hit;
    int                pick;
    int                k;
    logic [SIZE_W-1:0] least;
    res   = '0;
    hit   = 1'b0;
    pick  = 0;
    least = '0;
    if (act == ACT_CLEAR) begin
      open_cnt = 0;
      return res;
    end
    if (sz > cap_q) begin
      res.status = ST_OVER;
      return res;
    end
    if (mode_q == MODE_NEXT) begin
      if (open_cnt > 0 && sz <= room_q[open_cnt-1]) begin
        pick = open_cnt - 1;
        hit  = 1'b1;
      end
    end else if (mode_q == MODE_FIRST) begin
      for (k = 0; k < open_cnt && !hit; k++) begin
        if (sz <= room_q[k]) begin
          pick = k;
          hit  = 1'b1;
        end
      end
    end else begin
      // Best fit; the unused mode code falls here as well. Strict less-than keeps ties low.
      for (k = 0; k < open_cnt; k++) begin
        if (sz <= room_q[k] && (!hit || (room_q[k] - sz) < least)) begin
          least = room_q[k] - sz;
          pick  = k;
          hit   = 1'b1;
        end
      end
    end
    if (hit) begin
      room_q[pick]  = room_q[pick] - sz;
      res.bin_index = pick[IDX_W-1:0];
    end else if (open_cnt >= MAX_BINS) begin
      res.status = ST_FULL;
    end else begin
      room_q[open_cnt] = cap_q - sz;
      res.bin_index    = open_cnt[IDX_W-1:0];
      res.opened_new   = 1'b1;
      open_cnt++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    if (!rst_n) begin
      open_cnt = 0;
      cap_q    = CAPACITY_RESET;
      mode_q   = MODE_FIRST;
      placement_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CAPACITY) cap_q = cfg_data;
        else if (cfg_index == REG_MODE) mode_q = cfg_data[MODE_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        got = placement_t'(out_tdata[8:0]);
        if (placement_q.size() == 0) begin
          $error("result word with no placement pending: bin_index %0d opened_new %0d status %0d",
                 got.bin_index, got.opened_new, got.status);
          fail_cnt++;
        end else begin
          want = placement_q.pop_front();
          checked_cnt++;
          if (got.bin_index !== want.bin_index) begin
            $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
            fail_cnt++;
          end
          if (got.opened_new !== want.opened_new) begin
            $error("opened_new: expected %0d, got %0d", want.opened_new, got.opened_new);
            fail_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
          end
          if (out_tdata[15:9] !== 7'd0) begin
            $error("pad: expected %0d, got %0d", 0, out_tdata[15:9]);
            fail_cnt++;
          end
          if (want.opened_new) new_cnt++;
          if (want.status == ST_OVER) over_cnt++;
          if (want.status == ST_FULL) full_cnt++;
        end
      end
      if (in_tvalid && in_tready)
        placement_q.push_back(place_item(in_tuser[0], in_tdata[SIZE_W-1:0]));
      pending <= placement_q.size();
    end
  end

  initial begin
    fail_cnt    = 0;
    checked_cnt = 0;
    new_cnt     = 0;
    over_cnt    = 0;
    full_cnt    = 0;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import obpa_pkg::*;

  localparam int RAND_ITEMS = 1900;
  localparam int CALM_FROM  = 1700;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [SIZE_W-1:0]    cfg_data   = '0;

  int errors;
  int pending;
  int checked;
  int new_bins;
  int over_hits;
  int full_hits;

  int                gap_pct   = 0;
  int                stall_pct = 30;
  bit                calm      = 1'b0;
  logic [SIZE_W-1:0] cur_cap   = CAPACITY_RESET;
  int                rand_sent = 0;
  int                phases    = 0;
  int                clears    = 0;

  online_bin_packing_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bin_alloc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .new_bins  (new_bins),
    .over_hits (over_hits),
    .full_hits (full_hits)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("online_bin_packing_allocator verification failed");
    $finish;
  end

  // Result side back-pressure in random bursts; none once the run winds down.
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  end

  // Leaves tvalid high on return so that back-to-back words need no low cycle.
  task automatic push_word(input logic act, input logic [SIZE_W-1:0] sz);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, sz};
    in_tuser  <= act;
    if (act == ACT_CLEAR) clears++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [SIZE_W-1:0] cap, input logic [SIZE_W-1:0] mode_word,
                          input bit do_cap, input bit do_mode);
    settle();
    if (do_cap) begin
      write_reg(REG_CAPACITY, cap);
      cur_cap = cap;
    end
    if (do_mode) write_reg(REG_MODE, mode_word);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic random_item();
    int                r;
    logic [SIZE_W-1:0] sz;
    r = $urandom_range(0, 99);
    if (r < 1) begin
      push_word(ACT_CLEAR, SIZE_W'($urandom_range(0, 1023)));
    end else begin
      if (r < 7 && cur_cap < 10'd1023) sz = SIZE_W'($urandom_range(cur_cap + 1, 1023));
      else if (r < 7) sz = SIZE_W'($urandom_range(0, 1023));
      else if (r < 11) sz = '0;
      else if (r < 15) sz = cur_cap;
      else if (r < 60) sz = SIZE_W'($urandom_range(0, cur_cap));
      else sz = SIZE_W'($urandom_range(0, (cur_cap + 3) / 4));
      push_word(ACT_PLACE, sz);
    end
    rand_sent++;
  endtask

  int                len;
  int                j;
  int                pick_cap;
  int                fit;
  int                junk;
  logic [SIZE_W-1:0] new_cap;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: capacity 700, first fit.
    push_word(ACT_PLACE, 10'd0);     // zero size with nothing open opens bin 0
    push_word(ACT_PLACE, 10'd700);   // exactly fills bin 0
    push_word(ACT_PLACE, 10'd701);   // one over capacity
    push_word(ACT_PLACE, 10'd1023);
    push_word(ACT_PLACE, 10'd0);     // zero size still fits a full bin
    push_word(ACT_PLACE, 10'd300);
    push_word(ACT_PLACE, 10'd350);
    push_word(ACT_CLEAR, 10'd1023);

    set_regs(10'd1023, {8'd0, MODE_NEXT}, 1'b1, 1'b1);
    push_word(ACT_PLACE, 10'd1023);
    push_word(ACT_PLACE, 10'd1);
    push_word(ACT_PLACE, 10'd600);
    push_word(ACT_PLACE, 10'd500);   // next fit ignores room in older bins

    set_regs(10'd0, {8'd0, MODE_BEST}, 1'b0, 1'b1);
    push_word(ACT_PLACE, 10'd422);
    push_word(ACT_PLACE, 10'd100);
    push_word(ACT_PLACE, 10'd23);
    push_word(ACT_PLACE, 10'd623);

    // The spare mode code; two bins now tie on room left.
    set_regs(10'd0, {8'hff, 2'd3}, 1'b0, 1'b1);
    push_word(ACT_PLACE, 10'd10);

    // Shrinking the capacity leaves open bins with their old room.
    set_regs(10'd1, 10'd0, 1'b1, 1'b0);
    push_word(ACT_PLACE, 10'd2);
    push_word(ACT_PLACE, 10'd1);
    push_word(ACT_PLACE, 10'd0);

    while (rand_sent < RAND_ITEMS) begin
      pick_cap = $urandom_range(0, 5);
      case (pick_cap)
        0: new_cap = 10'd1;
        1: new_cap = 10'd1023;
        2: new_cap = SIZE_W'($urandom_range(1, 1023));
        3: new_cap = SIZE_W'($urandom_range(1, 31));
        default: new_cap = SIZE_W'($urandom_range(200, 1023));
      endcase
      fit  = $urandom_range(0, 3);
      junk = $urandom_range(0, 1) ? $urandom_range(0, 255) : 0;
      case ($urandom_range(0, 3))
        0: set_regs(new_cap, {junk[7:0], fit[1:0]}, 1'b1, 1'b0);
        1: set_regs(new_cap, {junk[7:0], fit[1:0]}, 1'b0, 1'b1);
        default: set_regs(new_cap, {junk[7:0], fit[1:0]}, 1'b1, 1'b1);
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 50;
      endcase
      if ($urandom_range(0, 1)) begin
        push_word(ACT_CLEAR, SIZE_W'($urandom_range(0, 1023)));
        rand_sent++;
      end
      len = $urandom_range(20, 120);
      for (j = 0; j < len && rand_sent < RAND_ITEMS; j++) begin
        calm = (rand_sent >= CALM_FROM);
        random_item();
      end
    end

    settle();
    repeat (80) @(posedge clk);
    $display("Checked %0d results across %0d register settings, %0d clear words included.",
             checked, phases, clears);
    $display("Bins opened: %0d, oversized items: %0d, refusals with every bin in use: %0d.",
             new_bins, over_hits, full_hits);
    if (errors == 0)
      $display("online_bin_packing_allocator verification clean");
    else
      $display("online_bin_packing_allocator verification failed");
    $finish;
  end

endmodule
